@@ rtl/core/kcg_pkg.sv @@
// ----------------------------------------------------------------------------
// kcg_pkg: shared types and constants for the keyspace candidate generator
// Request and response payloads, divider handshake structs, sequencer states.
// ----------------------------------------------------------------------------
package kcg_pkg;

  // Table and candidate geometry
  localparam int TABLE_DEPTH = 128;
  localparam int TAB_AW      = $clog2(TABLE_DEPTH);
  localparam int LONGEST     = 8;
  localparam int LEN_W       = 4;
  localparam int SLOT_W      = 3;
  localparam int CH_W        = 8;

  // Index arithmetic
  localparam int IDX_W  = 57;
  localparam int PWR_W  = IDX_W + 1;
  localparam int BASE_W = 8;
  localparam int PROD_W = PWR_W + BASE_W;
  localparam logic [PWR_W-1:0] CAP = {1'b1, {IDX_W{1'b0}}};

  // Shared divider: 64-bit accumulator, 8 quotient bits per cycle
  localparam int DVS_W    = 9;
  localparam int DIV_W    = 64;
  localparam int DIV_STEP = 8;
  localparam int DIV_CYC  = DIV_W / DIV_STEP;
  localparam int DIV_CW   = $clog2(DIV_CYC);

  // Request types
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_RESTART = 2'd1;
  localparam logic [1:0] REQ_NEXT    = 2'd2;

  // Response status codes
  localparam logic [1:0] STAT_LOADED    = 2'd0;
  localparam logic [1:0] STAT_PART_RDY  = 2'd1;
  localparam logic [1:0] STAT_CHAR      = 2'd2;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHARSET = 2'd0;
  localparam logic [1:0] CFG_MAXLEN  = 2'd1;
  localparam logic [1:0] CFG_WIDX    = 2'd2;
  localparam logic [1:0] CFG_WCNT    = 2'd3;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [6:0]      entry_position;
    logic [CH_W-1:0] entry_char;
  } kcg_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CH_W-1:0]   cand_char;
    logic [SLOT_W-1:0] char_slot;
    logic [LEN_W-1:0]  cand_length;
    logic              last_char;
    logic [IDX_W-1:0]  done_count;
    logic [IDX_W-1:0]  keyspace_total;
  } kcg_rsp_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_MUL,
    ST_KS_ADD,
    ST_KS_SPLIT,
    ST_KS_DIV,
    ST_KS_MULW,
    ST_KS_START,
    ST_KS_FIN,
    ST_PART_OUT,
    ST_LEN_SRCH,
    ST_DIG_GO,
    ST_DIG_WAIT,
    ST_DIG_CAP,
    ST_CHR_OUT
  } kcg_state_t;

endpackage

@@ rtl/core/keyspace_candidate_generator.sv @@
// ----------------------------------------------------------------------------
// keyspace_candidate_generator: brute-force candidate enumerator
// Sequencer around one shared multiplier and one shared iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req): load a table entry, restart the
//   partition, or ask for the next candidate. rsp channel (rsp_valid/
//   rsp_ready/rsp): one response per load or restart, one per character for
//   a candidate (last_char on the final one), or one exhausted response.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the four
//   registers; it is always ready. Write it only while no request is open.
// Sequence, one request at a time (L = effective length):
//   load, exhausted next: response register loaded at the acceptance edge.
//   restart: one multiply-add step per length up to L, a split, the divider,
//     placement of the share (KS_MULW, KS_START, KS_FIN), then the response
//     register; a split with no valid worker share goes straight to it.
//   next: length search, then per character a divider start, the divider
//     and a table capture, then the characters out, one per cycle while the
//     receiver takes them, last_char on the final one.
// req_ready is low while a request is in progress and while the response
// register is full and not being taken. A stalled receiver holds the block.
// Reset: synchronous; configuration registers return to defaults, partition state clears.
// The character table is not cleared.
// ----------------------------------------------------------------------------
module keyspace_candidate_generator (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  kcg_pkg::kcg_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output kcg_pkg::kcg_rsp_t rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data
);

  import kcg_pkg::*;

  // Configuration registers
  logic [7:0] symbol_count;
  logic [3:0] length_limit;
  logic [7:0] worker_index;
  logic [8:0] worker_count;

  // Architectural state
  logic [IDX_W-1:0] keyspace_size;
  logic [IDX_W-1:0] share_start;
  logic [IDX_W-1:0] share_end;
  logic [IDX_W-1:0] next_index;

  // Working registers
  kcg_state_t        state;
  kcg_state_t        state_next;
  logic [PWR_W-1:0]  power;
  logic [IDX_W-1:0]  total;
  logic [LEN_W-1:0]  lcnt;
  logic [IDX_W-1:0]  per;
  logic [DVS_W-1:0]  rem_w;
  logic [IDX_W-1:0]  prod_r;
  logic [IDX_W-1:0]  cum;
  logic [LEN_W-1:0]  clen;
  logic [IDX_W-1:0]  offset;
  logic [LEN_W-1:0]  dn;
  logic [SLOT_W-1:0] slot;
  logic [CH_W-1:0]   digits [LONGEST];

  // Combinational helpers
  logic [BASE_W-1:0] base;
  logic [LEN_W-1:0]  eff_len;
  logic              rsp_free;
  logic              rsp_load;
  kcg_rsp_t          rsp_next;
  logic [PWR_W-1:0]  mul_a;
  logic [BASE_W-1:0] mul_b;
  logic [PROD_W-1:0] product;
  logic [PWR_W-1:0]  mul_sat;
  logic [PWR_W-1:0]  tsum;
  logic [IDX_W+1:0]  sum_cum;
  logic              grow;
  logic              share_valid;
  logic              share_empty;
  logic              min_lt;
  logic [DVS_W-1:0]  min_w;
  logic              chr_last;
  logic              pos_ok;
  logic              ram_we;
  logic [CH_W-1:0]   ram_rdata;
  logic              div_start;
  div_req_t          dreq;
  div_rsp_t          drsp;

  // Effective base and length, clamped to table and candidate limits
  assign base    = (9'(symbol_count) > 9'(TABLE_DEPTH)) ? BASE_W'(TABLE_DEPTH) : symbol_count;
  assign eff_len = (5'(length_limit) > 5'(LONGEST)) ? LEN_W'(LONGEST) : length_limit;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE) && rsp_free;
  assign cfg_ready = 1'b1;

  // Shared saturating multiplier: power*base, or per*worker_index on split
  assign mul_a   = (state == ST_KS_MULW) ? {1'b0, per} : power;
  assign mul_b   = (state == ST_KS_MULW) ? worker_index : base;
  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign mul_sat = (product > PROD_W'(CAP)) ? CAP : product[PWR_W-1:0];

  // Keyspace accumulation, saturating at all ones
  assign tsum = {1'b0, total} + power;

  // Length search step
  assign sum_cum = {2'b0, cum} + {1'b0, power};
  assign grow    = (sum_cum <= {2'b0, next_index}) && (clen < eff_len);

  // Share checks
  assign share_valid = (worker_count != '0) && ({1'b0, worker_index} < worker_count);
  assign share_empty = (next_index >= share_end) || (base == '0) || (eff_len == '0);
  assign min_lt      = {1'b0, worker_index} < rem_w;
  assign min_w       = min_lt ? {1'b0, worker_index} : rem_w;

  assign chr_last = (LEN_W'(slot) + LEN_W'(1)) == clen;
  assign pos_ok   = 9'(req.entry_position) < 9'(TABLE_DEPTH);

  // Divider request
  assign dreq = '{start:    div_start,
                  dividend: (state == ST_KS_SPLIT) ? total : offset,
                  divisor:  (state == ST_KS_SPLIT) ? worker_count : {1'b0, base}};

  kcg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .dreq (dreq),
    .drsp (drsp)
  );

  // Character table; read address follows the divider remainder
  kcg_ram #(
    .WIDTH (CH_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (TAB_AW'(req.entry_position)),
    .wdata (req.entry_char),
    .raddr (drsp.remainder[TAB_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes
  always_comb begin
    state_next              = state;
    rsp_load                = 1'b0;
    ram_we                  = 1'b0;
    div_start               = 1'b0;
    rsp_next                = '0;
    rsp_next.done_count     = next_index - share_start;
    rsp_next.keyspace_total = keyspace_size;
    case (state)
      ST_IDLE: begin
        if (req_valid && rsp_free) begin
          case (req.req_type)
            REQ_LOAD: begin
              ram_we             = pos_ok;
              rsp_load           = 1'b1;
              rsp_next.status    = STAT_LOADED;
              rsp_next.last_char = 1'b1;
            end
            REQ_RESTART: state_next = ST_KS_MUL;
            REQ_NEXT: begin
              if (share_empty) begin
                rsp_load           = 1'b1;
                rsp_next.status    = STAT_EXHAUSTED;
                rsp_next.last_char = 1'b1;
              end else begin
                state_next = ST_LEN_SRCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_KS_MUL:   state_next = (lcnt == eff_len) ? ST_KS_SPLIT : ST_KS_ADD;
      ST_KS_ADD:   state_next = ST_KS_MUL;
      ST_KS_SPLIT: begin
        if (share_valid) begin
          div_start  = 1'b1;
          state_next = ST_KS_DIV;
        end else begin
          state_next = ST_PART_OUT;
        end
      end
      ST_KS_DIV:   if (drsp.done) state_next = ST_KS_MULW;
      ST_KS_MULW:  state_next = ST_KS_START;
      ST_KS_START: state_next = ST_KS_FIN;
      ST_KS_FIN:   state_next = ST_PART_OUT;
      ST_PART_OUT: begin
        if (rsp_free) begin
          rsp_load           = 1'b1;
          rsp_next.status    = STAT_PART_RDY;
          rsp_next.last_char = 1'b1;
          state_next         = ST_IDLE;
        end
      end
      ST_LEN_SRCH: if (!grow) state_next = ST_DIG_GO;
      ST_DIG_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIG_WAIT;
      end
      ST_DIG_WAIT: if (drsp.done) state_next = ST_DIG_CAP;
      ST_DIG_CAP:  state_next = (dn == '0) ? ST_CHR_OUT : ST_DIG_GO;
      ST_CHR_OUT: begin
        if (rsp_free) begin
          rsp_load             = 1'b1;
          rsp_next.status      = STAT_CHAR;
          rsp_next.cand_char   = digits[slot];
          rsp_next.char_slot   = slot;
          rsp_next.cand_length = clen;
          rsp_next.last_char   = chr_last;
          if (chr_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= 8'd62;
      length_limit <= 4'd8;
      worker_index <= 8'd0;
      worker_count <= 9'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CHARSET: symbol_count <= cfg_data[7:0];
        CFG_MAXLEN:  length_limit <= cfg_data[3:0];
        CFG_WIDX:    worker_index <= cfg_data[7:0];
        CFG_WCNT:    worker_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Partition state and index
  always_ff @(posedge clk) begin
    if (rst) begin
      keyspace_size <= '0;
      share_start   <= '0;
      share_end     <= '0;
      next_index    <= '0;
    end else begin
      case (state)
        ST_KS_SPLIT: begin
          keyspace_size <= total;
          if (!share_valid) begin
            share_start <= '0;
            share_end   <= '0;
            next_index  <= '0;
          end
        end
        ST_KS_START: begin
          share_start <= prod_r + IDX_W'(min_w);
          next_index  <= prod_r + IDX_W'(min_w);
        end
        ST_KS_FIN: share_end <= share_start + per + IDX_W'(min_lt);
        ST_DIG_CAP: begin
          if (dn == '0) begin
            next_index <= next_index + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        total <= '0;
        power <= (req.req_type == REQ_RESTART) ? PWR_W'(1) : PWR_W'(base);
        lcnt  <= '0;
        cum   <= '0;
        clen  <= LEN_W'(1);
      end
      ST_KS_MUL: begin
        if (lcnt != eff_len) begin
          power <= mul_sat;
        end
      end
      ST_KS_ADD: begin
        total <= tsum[IDX_W] ? {IDX_W{1'b1}} : tsum[IDX_W-1:0];
        lcnt  <= lcnt + LEN_W'(1);
      end
      ST_KS_DIV: begin
        if (drsp.done) begin
          per   <= drsp.quotient;
          rem_w <= drsp.remainder;
        end
      end
      ST_KS_MULW: prod_r <= mul_sat[IDX_W-1:0];
      ST_LEN_SRCH: begin
        if (grow) begin
          cum   <= sum_cum[IDX_W-1:0];
          clen  <= clen + LEN_W'(1);
          power <= mul_sat;
        end else begin
          offset <= next_index - cum;
          dn     <= clen;
        end
      end
      ST_DIG_WAIT: begin
        if (drsp.done) begin
          offset <= drsp.quotient;
          dn     <= dn - LEN_W'(1);
        end
      end
      ST_DIG_CAP: begin
        digits[dn[SLOT_W-1:0]] <= ram_rdata;
        slot                   <= '0;
      end
      ST_CHR_OUT: begin
        if (rsp_free) begin
          slot <= slot + SLOT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ rtl/core/kcg_ram.sv @@
// ----------------------------------------------------------------------------
// kcg_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/kcg_div.sv @@
// ----------------------------------------------------------------------------
// kcg_div: shared iterative divider
// Restoring division of a 57-bit dividend by a 9-bit divisor, 8 bits a cycle.
// ----------------------------------------------------------------------------
module kcg_div (
  input  logic               clk,
  input  logic               rst,
  input  kcg_pkg::div_req_t  dreq,
  output kcg_pkg::div_rsp_t  drsp
);

  import kcg_pkg::*;

  logic              busy;
  logic              done;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_W-1:0]  acc;
  logic [DIV_W-1:0]  acc_next;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  rem_next;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    trial;

  // Eight compare-subtract steps per cycle; quotient bits shift into acc
  always_comb begin
    acc_next = acc;
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial    = {rem_next, acc_next[DIV_W-1]};
      acc_next = {acc_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_next    = DVS_W'(trial - {1'b0, dvs});
        acc_next[0] = 1'b1;
      end else begin
        rem_next = trial[DVS_W-1:0];
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (dreq.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CW'(1);
        if (cnt == DIV_CW'(DIV_CYC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (dreq.start) begin
      acc <= DIV_W'(dreq.dividend);
      rem <= '0;
      dvs <= dreq.divisor;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign drsp = '{done: done, quotient: acc[IDX_W-1:0], remainder: rem};

endmodule

@@ verif/kcg_checker.sv @@
// ----------------------------------------------------------------------------
// kcg_checker: response checker for the keyspace candidate generator
// Watches the request, response and register channels, predicts every
// response from its own copy of the table, registers and partition state,
// and compares each accepted response field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcg_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic              req_ready,
  input  wire kcg_pkg::kcg_req_t req,
  input  wire logic              rsp_valid,
  input  wire logic              rsp_ready,
  input  wire kcg_pkg::kcg_rsp_t rsp,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [8:0]        cfg_data,
  output int                     errors,
  output int                     pending
);
  import kcg_pkg::*;

  localparam logic [63:0] IDX_MASK = (64'd1 << IDX_W) - 64'd1;
  localparam logic [63:0] CAP_64   = 64'd1 << IDX_W;

  // Shadow of the block's table, registers and partition state
  logic [CH_W-1:0] chars [TABLE_DEPTH];
  logic [63:0]     ks_size, sh_start, sh_end, cursor;
  logic [7:0]      r_charset;
  logic [3:0]      r_maxlen;
  logic [7:0]      r_widx;
  logic [8:0]      r_wcnt;

  // Responses owed by the block, oldest first
  kcg_rsp_t        awaited [$];
  kcg_rsp_t        want;
  int              err_cnt = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    err_cnt++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $time);
  endtask

  function automatic logic [63:0] clamp_mul(input logic [63:0] a, input logic [63:0] b);
    logic [71:0] prod;
    prod = a * b;
    return (prod > {8'd0, CAP_64}) ? CAP_64 : prod[63:0];
  endfunction

  function automatic logic [63:0] base_now();
    return (r_charset > TABLE_DEPTH) ? 64'(TABLE_DEPTH) : 64'(r_charset);
  endfunction

  function automatic logic [63:0] len_now();
    return (r_maxlen > LONGEST) ? 64'(LONGEST) : 64'(r_maxlen);
  endfunction

  task automatic push_rsp(input logic [1:0] st, input logic [CH_W-1:0] ch,
                          input logic [SLOT_W-1:0] slot, input logic [LEN_W-1:0] ln,
                          input logic is_last);
    kcg_rsp_t    r;
    logic [63:0] diff;
    diff             = cursor - sh_start;
    r.status         = st;
    r.cand_char      = ch;
    r.char_slot      = slot;
    r.cand_length    = ln;
    r.last_char      = is_last;
    r.done_count     = diff[IDX_W-1:0];
    r.keyspace_total = ks_size[IDX_W-1:0];
    awaited.push_back(r);
  endtask

  // Restart: keyspace sum over lengths, then this worker's share
  task automatic split_keyspace();
    logic [63:0] base, ln, total, pw, per, rem, wi, wc;
    base  = base_now();
    ln    = len_now();
    total = 0;
    pw    = 1;
    for (int l = 1; l <= ln; l++) begin
      pw    = clamp_mul(pw, base);
      total = total + pw;
      if (total > IDX_MASK) total = IDX_MASK;
    end
    ks_size = total;
    wi = 64'(r_widx);
    wc = 64'(r_wcnt);
    if (wc == 0 || wi >= wc) begin
      sh_start = 0;
      sh_end   = 0;
    end else begin
      per      = total / wc;
      rem      = total % wc;
      sh_start = wi * per + ((wi < rem) ? wi : rem);
      sh_end   = sh_start + per + ((wi < rem) ? 64'd1 : 64'd0);
    end
    cursor = sh_start;
    push_rsp(STAT_PART_RDY, '0, '0, '0, 1'b1);
  endtask

  // Next: exhausted if the share is used up, else find the length block, peel base digits, one char per response
  task automatic enumerate_candidate();
    logic [63:0]     base, maxl, cum, pw, len, offs;
    logic [CH_W-1:0] digs [LONGEST];
    base = base_now();
    maxl = len_now();
    if (cursor >= sh_end || base == 0 || maxl == 0) begin
      push_rsp(STAT_EXHAUSTED, '0, '0, '0, 1'b1);
    end else begin
      cum = 0;
      pw  = base;
      len = 1;
      while (cum + pw <= cursor && len < maxl) begin
        cum = cum + pw;
        len = len + 1;
        pw  = clamp_mul(pw, base);
      end
      offs = cursor - cum;
      for (int i = int'(len) - 1; i >= 0; i--) begin
        digs[i] = chars[offs % base];
        offs    = offs / base;
      end
      cursor = (cursor + 64'd1) & IDX_MASK;
      for (int n = 0; n < int'(len); n++) begin
        push_rsp(STAT_CHAR, digs[n], SLOT_W'(n), LEN_W'(len), (n + 1 == int'(len)));
      end
    end
  endtask

  // Compare first: a response taken at the same edge as a request is older
  always @(posedge clk) begin
    if (rst) begin
      ks_size   = 0;
      sh_start  = 0;
      sh_end    = 0;
      cursor    = 0;
      r_charset = 8'd62;
      r_maxlen  = 4'd8;
      r_widx    = 8'd0;
      r_wcnt    = 9'd1;
      awaited.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited.size() == 0) begin
          report_mismatch("response with none outstanding, status", 64'(rsp.status),
                          64'd0);
        end else begin
          want = awaited.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.cand_char !== want.cand_char)
            report_mismatch("cand_char", 64'(rsp.cand_char), 64'(want.cand_char));
          if (rsp.char_slot !== want.char_slot)
            report_mismatch("char_slot", 64'(rsp.char_slot), 64'(want.char_slot));
          if (rsp.cand_length !== want.cand_length)
            report_mismatch("cand_length", 64'(rsp.cand_length), 64'(want.cand_length));
          if (rsp.last_char !== want.last_char)
            report_mismatch("last_char", 64'(rsp.last_char), 64'(want.last_char));
          if (rsp.done_count !== want.done_count)
            report_mismatch("done_count", 64'(rsp.done_count), 64'(want.done_count));
          if (rsp.keyspace_total !== want.keyspace_total)
            report_mismatch("keyspace_total", 64'(rsp.keyspace_total),
                            64'(want.keyspace_total));
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHARSET: r_charset = cfg_data[7:0];
          CFG_MAXLEN:  r_maxlen  = cfg_data[3:0];
          CFG_WIDX:    r_widx    = cfg_data[7:0];
          CFG_WCNT:    r_wcnt    = cfg_data;
          default: ;
        endcase
      end

      if (req_valid && req_ready) begin
        case (req.req_type)
          REQ_LOAD: begin
            chars[req.entry_position] = req.entry_char;
            push_rsp(STAT_LOADED, '0, '0, '0, 1'b1);
          end
          REQ_RESTART: split_keyspace();
          REQ_NEXT:    enumerate_candidate();
          default: ;
        endcase
      end
    end
    pending <= awaited.size();
    errors  <= err_cnt;
  end

endmodule

`default_nettype wire

@@ verif/tb_keyspace_candidate_generator.sv @@
// ----------------------------------------------------------------------------
// tb_keyspace_candidate_generator: top of the candidate generator testbench
// Drives load, restart, next and unused requests plus register writes through
// directed corners, a full table fill and randomized partition rounds, with
// random idling on both sides and one long response stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_keyspace_candidate_generator;
  import kcg_pkg::*;

  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam int         ITEM_TARGET   = 170;
  localparam int         PHASE_SWAP    = 60;
  localparam int         PHASE_FREE    = 120;
  localparam int         QUIET_LIMIT   = 3000;
  localparam int         SETTLE_CYCLES = 200;
  localparam int         HOLD_AT       = 45;
  localparam int         HOLD_LEN      = 400;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  kcg_req_t          req;
  logic              rsp_valid;
  logic              rsp_ready;
  kcg_rsp_t          rsp;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [8:0]        cfg_data;

  int                errors;
  int                pending;
  int                items_sent = 0;
  int                snd_idle   = 35;
  int                rcv_idle   = 73;
  int                hold_left  = 0;
  bit                hold_done  = 1'b0;
  int                quiet      = 0;

  keyspace_candidate_generator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kcg_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Response side: random back-pressure, plus one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Watchdog: nothing moving on any channel for too long
  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // One request; valid stays up until taken
  task automatic send(input logic [1:0] kind, input logic [6:0] pos,
                      input logic [7:0] ch);
    while ($urandom_range(99) < snd_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{req_type: kind, entry_position: pos, entry_char: ch};
    do @(posedge clk); while (!req_ready);
    items_sent++;
    if (items_sent < PHASE_SWAP) begin
      snd_idle = 35;
      rcv_idle = 73;
    end else if (items_sent < PHASE_FREE) begin
      snd_idle = 73;
      rcv_idle = 35;
    end else begin
      snd_idle = 0;
      rcv_idle = 0;
    end
  endtask

  // Request with a random payload, used only by loads
  task automatic send_blind(input logic [1:0] kind);
    send(kind, 7'($urandom), 8'($urandom));
  endtask

  // Drain all owed responses, then let a request with no response finish
  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(input logic [7:0] cs, input logic [3:0] ml,
                          input logic [7:0] wi, input logic [8:0] wc);
    settle();
    write_reg(CFG_CHARSET, {1'b0, cs});
    write_reg(CFG_MAXLEN, {5'd0, ml});
    write_reg(CFG_WIDX, {1'b0, wi});
    write_reg(CFG_WCNT, wc);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int         order [TABLE_DEPTH];
    int         reps;
    int         t;
    int         j;
    logic [7:0] cs;
    logic [7:0] wi;
    logic [3:0] ml;
    logic [8:0] wc;

    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CHARSET;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: next before any restart is exhausted, unknown type ignored
    send_blind(REQ_NEXT);
    send_blind(REQ_UNUSED);
    send(REQ_LOAD, 7'd0, 8'h00);
    send(REQ_LOAD, 7'd127, 8'hFF);
    send(REQ_LOAD, 7'd1, 8'h5A);
    send(REQ_LOAD, 7'd2, 8'hA5);
    send_blind(REQ_RESTART);
    send_blind(REQ_NEXT);
    send_blind(REQ_NEXT);

    // Uneven split: worker 1 of 5 over 12 candidates, run past its share
    set_regs(8'd3, 4'd2, 8'd1, 9'd5);
    send_blind(REQ_RESTART);
    repeat (4) send_blind(REQ_NEXT);

    // Zero base with oversized length
    set_regs(8'd0, 4'd15, 8'd0, 9'd1);
    send_blind(REQ_RESTART);
    send_blind(REQ_NEXT);

    // Zero worker count gives an empty share
    set_regs(8'd2, 4'd3, 8'd0, 9'd0);
    send_blind(REQ_RESTART);
    send_blind(REQ_NEXT);

    // Zero length
    set_regs(8'd3, 4'd0, 8'd0, 9'd1);
    send_blind(REQ_RESTART);
    send_blind(REQ_NEXT);

    // Base changed after restart: digits decode with the new base
    set_regs(8'd3, 4'd2, 8'd0, 9'd1);
    send_blind(REQ_RESTART);
    send_blind(REQ_NEXT);
    settle();
    write_reg(CFG_CHARSET, 9'd2);
    cfg_valid <= 1'b0;
    send_blind(REQ_NEXT);
    send_blind(REQ_NEXT);

    // Fill the whole table in random order
    for (int i = 0; i < TABLE_DEPTH; i++) order[i] = i;
    for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) send(REQ_LOAD, 7'(order[i]), 8'($urandom));

    // Random partition rounds, biased toward corners and deep shares
    while (items_sent < ITEM_TARGET) begin
      t = $urandom_range(19);
      if (t == 0)       cs = 8'd0;
      else if (t == 1)  cs = 8'd128;
      else if (t == 2)  cs = 8'd255;
      else if (t == 3)  cs = 8'($urandom_range(129, 254));
      else if (t <= 10) cs = 8'($urandom_range(1, 8));
      else              cs = 8'($urandom_range(1, 127));

      t = $urandom_range(19);
      if (t == 0)      ml = 4'd0;
      else if (t == 1) ml = 4'd15;
      else if (t <= 3) ml = 4'($urandom_range(9, 14));
      else if (t <= 9) ml = 4'd8;
      else             ml = 4'($urandom_range(1, 7));

      t = $urandom_range(9);
      if (t == 0)      wc = 9'd0;
      else if (t == 1) wc = 9'd256;
      else if (t == 2) wc = 9'($urandom_range(257, 511));
      else if (t == 3) wc = 9'd1;
      else             wc = 9'($urandom_range(2, 12));

      t = $urandom_range(9);
      if (t == 0)       wi = 8'd255;
      else if (t == 1)  wi = 8'($urandom_range(255));
      else if (wc == 0) wi = 8'd0;
      else if (t <= 4)  wi = (wc > 256) ? 8'd255 : 8'(wc - 1);
      else begin
        j  = $urandom_range(int'(wc) - 1);
        wi = (j > 255) ? 8'd255 : 8'(j);
      end

      set_regs(cs, ml, wi, wc);
      send_blind(REQ_RESTART);

      reps = $urandom_range(2, 10);
      for (int k = 0; k < reps; k++) begin
        t = $urandom_range(59);
        if (t < 5) begin
          send_blind(REQ_LOAD);
        end else if (t < 9) begin
          send_blind(REQ_UNUSED);
        end else if (t < 12) begin
          send_blind(REQ_RESTART);
        end else begin
          send_blind(REQ_NEXT);
        end
      end

      // Sometimes switch the base mid-share
      if ($urandom_range(3) == 0) begin
        settle();
        write_reg(CFG_CHARSET, 9'($urandom_range(1, 255)));
        cfg_valid <= 1'b0;
        send_blind(REQ_NEXT);
        send_blind(REQ_NEXT);
      end
    end

    // Drain and give the verdict
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
